// ===== src/srp_pkg.sv =====
// Shared types and codes for the shelf rectangle packer.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package srp_pkg;

    // Command opcodes as they arrive on the input stream
    localparam int OPCODE_BITS = 2;
    localparam logic [OPCODE_BITS-1:0] OP_PLACE     = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_LOAD      = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR     = 2'd2;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR_ALT = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIM_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIM_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIM_TOP    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIM_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAP         = 3'd4;

    // Result status codes
    localparam int STATUS_BITS = 3;
    typedef enum logic [STATUS_BITS-1:0] {
        ST_PLACED     = 3'd0,
        ST_LOADED     = 3'd1,
        ST_CLEARED    = 3'd2,
        ST_NO_SHEETS  = 3'd3,
        ST_EXHAUSTED  = 3'd4,
        ST_TOO_BIG    = 3'd5,
        ST_TABLE_FULL = 3'd6
    } t_status;

    localparam int SHEET_NUM_BITS = 6;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Decoded command kind
    typedef enum logic [1:0] {
        KIND_PLACE = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  rot_ok;   // turning allowed and the rectangle is not square
    } t_ctl;

endpackage

`default_nettype wire

// ===== src/srp_front.sv =====
// Front end of the packer: accepts stream words and decodes the command kind.
// Depends on srp_pkg.
`default_nettype none

module srp_front #(
    parameter int DIM_BITS = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [srp_pkg::OPCODE_BITS-1:0]  i_in_opcode,
    input  wire logic [DIM_BITS-1:0]              i_in_w,
    input  wire logic [DIM_BITS-1:0]              i_in_h,
    input  wire logic                             i_in_rot,
    output logic                                  o_cmd_valid,
    input  wire logic                             i_cmd_ready,
    output srp_pkg::t_ctl                         o_cmd_ctl,
    output logic [DIM_BITS-1:0]                   o_cmd_w,
    output logic [DIM_BITS-1:0]                   o_cmd_h
);
    import srp_pkg::*;

    logic                r_v;
    t_ctl                r_ctl;
    t_ctl                n_ctl;
    logic [DIM_BITS-1:0] r_w;
    logic [DIM_BITS-1:0] r_h;

    assign o_in_ready  = !r_v || i_cmd_ready;
    assign o_cmd_valid = r_v;
    assign o_cmd_ctl   = r_ctl;
    assign o_cmd_w     = r_w;
    assign o_cmd_h     = r_h;

    always_comb begin
        n_ctl.rot_ok = i_in_rot && (i_in_w != i_in_h);
        case (i_in_opcode) inside
            OP_PLACE:               n_ctl.kind = KIND_PLACE;
            OP_LOAD:                n_ctl.kind = KIND_LOAD;
            OP_CLEAR, OP_CLEAR_ALT: n_ctl.kind = KIND_CLEAR;
            default:                n_ctl.kind = KIND_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_in_ready) begin
            r_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ctl <= n_ctl;
            r_w   <= i_in_w;
            r_h   <= i_in_h;
        end
    end

endmodule

`default_nettype wire

// ===== src/srp_queue.sv =====
// Short command queue that decouples the packer front end from the back end.
// Depends on srp_pkg for its depth.
`default_nettype none

module srp_queue #(
    parameter int WIDTH = 51
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output logic [WIDTH-1:0]      o_pop_data
);
    import srp_pkg::*;

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/srp_back.sv =====
// Back end of the packer: sheet table, cursor state, placement and result register.
// Depends on srp_pkg; fed from srp_queue.
`default_nettype none

module srp_back #(
    parameter int MAX_SHEETS = 64,
    parameter int DIM_BITS   = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [srp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [DIM_BITS-1:0]                i_cfg_data,
    input  wire logic                               i_cmd_valid,
    output logic                                    o_cmd_ready,
    input  srp_pkg::t_ctl                           i_cmd_ctl,
    input  wire logic [DIM_BITS-1:0]                i_cmd_w,
    input  wire logic [DIM_BITS-1:0]                i_cmd_h,
    output logic                                    o_res_valid,
    input  wire logic                               i_res_ready,
    output srp_pkg::t_status                        o_res_status,
    output logic [srp_pkg::SHEET_NUM_BITS-1:0]      o_res_sheet,
    output logic [DIM_BITS-1:0]                     o_res_x,
    output logic [DIM_BITS-1:0]                     o_res_y,
    output logic [DIM_BITS-1:0]                     o_res_w,
    output logic [DIM_BITS-1:0]                     o_res_h,
    output logic                                    o_res_turned
);
    import srp_pkg::*;

    localparam int LW = $clog2(MAX_SHEETS + 1);
    localparam int AW = (MAX_SHEETS > 1) ? $clog2(MAX_SHEETS) : 1;
    localparam int CW = DIM_BITS + 2;
    localparam int SW = DIM_BITS + 3;

    // configuration
    logic [DIM_BITS-1:0] r_trim_l, r_trim_r, r_trim_t, r_trim_b, r_gap;
    logic [DIM_BITS:0]   r_trim_lr, r_trim_tb;

    // packing state
    logic [LW-1:0]       r_loaded, n_loaded;
    logic [LW-1:0]       r_sheet, n_sheet;
    logic [CW-1:0]       r_cx, n_cx;
    logic [CW-1:0]       r_cy, n_cy;
    logic [DIM_BITS-1:0] r_rh, n_rh;

    // sheet table, plus copies of the current and the following sheet
    logic [DIM_BITS-1:0] mem_w [MAX_SHEETS];
    logic [DIM_BITS-1:0] mem_h [MAX_SHEETS];
    logic [DIM_BITS-1:0] r_cur_w, r_cur_h;
    logic [DIM_BITS-1:0] r_nxt_w, r_nxt_h;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [LW:0]         rd_sum;
    logic                wr_en;
    logic                adv;

    // result register
    logic                      r_ov;
    t_status                   r_o_status, n_status;
    logic [SHEET_NUM_BITS-1:0] r_o_sheet, n_sn;
    logic [DIM_BITS-1:0]       r_o_x, r_o_y, r_o_w, r_o_h;
    logic                      r_o_turned;

    // placement arithmetic
    logic signed [SW-1:0] e_w, e_h, e_cx, e_cy, e_rh, e_gap, e_cy2;
    logic signed [SW-1:0] uw, uh, nuw, nuh;
    logic                 a0, a1, b0, b1, c0, c1;
    logic                 row_open, has_next, table_full, fire;
    logic [LW:0]          sheet_inc;
    logic [LW-1:0]        sn_src;
    logic [LW+SHEET_NUM_BITS-1:0] sn_ext;
    logic                 place_ok, p_turn;
    logic [CW-1:0]        p_x, p_y;
    logic [DIM_BITS-1:0]  p_w, p_h, rh_base;

    assign o_cmd_ready = !r_ov || i_res_ready;
    assign fire        = i_cmd_valid && o_cmd_ready;

    assign e_w   = $signed({3'b000, i_cmd_w});
    assign e_h   = $signed({3'b000, i_cmd_h});
    assign e_cx  = $signed({1'b0, r_cx});
    assign e_cy  = $signed({1'b0, r_cy});
    assign e_rh  = $signed({3'b000, r_rh});
    assign e_gap = $signed({3'b000, r_gap});
    assign e_cy2 = e_cy + e_rh + e_gap;
    assign uw    = $signed({3'b000, r_cur_w}) - $signed({2'b00, r_trim_lr});
    assign uh    = $signed({3'b000, r_cur_h}) - $signed({2'b00, r_trim_tb});
    assign nuw   = $signed({3'b000, r_nxt_w}) - $signed({2'b00, r_trim_lr});
    assign nuh   = $signed({3'b000, r_nxt_h}) - $signed({2'b00, r_trim_tb});

    // at the cursor, in a fresh row, and at the origin of the next sheet
    assign a0 = (e_cx + e_w <= uw) && (e_cy + e_h <= uh);
    assign a1 = i_cmd_ctl.rot_ok && (e_cx + e_h <= uw) && (e_cy + e_w <= uh);
    assign b0 = (e_w <= uw) && (e_cy2 + e_h <= uh);
    assign b1 = i_cmd_ctl.rot_ok && (e_h <= uw) && (e_cy2 + e_w <= uh);
    assign c0 = (e_w <= nuw) && (e_h <= nuh);
    assign c1 = i_cmd_ctl.rot_ok && (e_h <= nuw) && (e_w <= nuh);

    assign row_open   = (r_rh != '0);
    assign sheet_inc  = {1'b0, r_sheet} + (LW+1)'(1);
    assign has_next   = (sheet_inc < {1'b0, r_loaded});
    assign table_full = (r_loaded == LW'(MAX_SHEETS));

    always_comb begin
        n_loaded = r_loaded;
        n_sheet  = r_sheet;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_rh     = r_rh;
        n_status = ST_PLACED;
        sn_src   = '0;
        wr_en    = 1'b0;
        place_ok = 1'b0;
        p_turn   = 1'b0;
        p_x      = '0;
        p_y      = '0;
        rh_base  = '0;
        if (fire) begin
            case (i_cmd_ctl.kind)
                KIND_CLEAR: begin
                    n_loaded = '0;
                    n_sheet  = '0;
                    n_cx     = '0;
                    n_cy     = '0;
                    n_rh     = '0;
                    n_status = ST_CLEARED;
                end
                KIND_LOAD: begin
                    if (table_full) begin
                        n_status = ST_TABLE_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        n_loaded = r_loaded + LW'(1);
                        n_status = ST_LOADED;
                        sn_src   = r_loaded;
                    end
                end
                KIND_PLACE: begin
                    if (r_loaded == '0) begin
                        n_status = ST_NO_SHEETS;
                    end else if (a0 || a1) begin
                        place_ok = 1'b1;
                        p_turn   = !a0;
                        p_x      = r_cx;
                        p_y      = r_cy;
                        rh_base  = r_rh;
                    end else if (row_open && (b0 || b1)) begin
                        place_ok = 1'b1;
                        p_turn   = !b0;
                        p_y      = e_cy2[CW-1:0];
                    end else if (!has_next) begin
                        // keep the row that the failed try opened
                        n_status = ST_EXHAUSTED;
                        if (row_open) begin
                            n_cx = '0;
                            n_cy = e_cy2[CW-1:0];
                            n_rh = '0;
                        end
                    end else begin
                        n_sheet = sheet_inc[LW-1:0];
                        n_cx    = '0;
                        n_cy    = '0;
                        n_rh    = '0;
                        if (c0 || c1) begin
                            place_ok = 1'b1;
                            p_turn   = !c0;
                        end else begin
                            n_status = ST_TOO_BIG;
                        end
                    end
                end
                default: begin
                    n_status = ST_CLEARED;
                end
            endcase
        end
        p_w = p_turn ? i_cmd_h : i_cmd_w;
        p_h = p_turn ? i_cmd_w : i_cmd_h;
        if (place_ok) begin
            n_cx   = p_x + CW'(p_w) + CW'(r_gap);
            n_cy   = p_y;
            n_rh   = (p_h > rh_base) ? p_h : rh_base;
            sn_src = n_sheet;
        end
    end

    assign sn_ext = {{SHEET_NUM_BITS{1'b0}}, sn_src};
    assign n_sn   = sn_ext[SHEET_NUM_BITS-1:0];
    assign adv    = fire && (i_cmd_ctl.kind == KIND_PLACE) && (n_sheet != r_sheet);

    // read the slot after the sheet that the next command will work on
    assign wr_addr = r_loaded[AW-1:0];
    assign rd_sum  = {1'b0, n_sheet} + (LW+1)'(1);
    assign rd_addr = rd_sum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_w[wr_addr] <= i_cmd_w;
            mem_h[wr_addr] <= i_cmd_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            r_nxt_w <= i_cmd_w;
            r_nxt_h <= i_cmd_h;
        end else begin
            r_nxt_w <= mem_w[rd_addr];
            r_nxt_h <= mem_h[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (r_loaded == r_sheet)) begin
            r_cur_w <= i_cmd_w;
            r_cur_h <= i_cmd_h;
        end else if (adv) begin
            r_cur_w <= r_nxt_w;
            r_cur_h <= r_nxt_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim_l  <= '0;
            r_trim_r  <= '0;
            r_trim_t  <= '0;
            r_trim_b  <= '0;
            r_gap     <= '0;
            r_trim_lr <= '0;
            r_trim_tb <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRIM_LEFT: begin
                    r_trim_l  <= i_cfg_data;
                    r_trim_lr <= {1'b0, i_cfg_data} + {1'b0, r_trim_r};
                end
                CFG_TRIM_RIGHT: begin
                    r_trim_r  <= i_cfg_data;
                    r_trim_lr <= {1'b0, r_trim_l} + {1'b0, i_cfg_data};
                end
                CFG_TRIM_TOP: begin
                    r_trim_t  <= i_cfg_data;
                    r_trim_tb <= {1'b0, i_cfg_data} + {1'b0, r_trim_b};
                end
                CFG_TRIM_BOTTOM: begin
                    r_trim_b  <= i_cfg_data;
                    r_trim_tb <= {1'b0, r_trim_t} + {1'b0, i_cfg_data};
                end
                CFG_GAP: begin
                    r_gap <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_sheet  <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_rh     <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_loaded <= n_loaded;
            r_sheet  <= n_sheet;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_rh     <= n_rh;
            if (fire) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_status <= n_status;
            r_o_sheet  <= n_sn;
            r_o_x      <= place_ok ? p_x[DIM_BITS-1:0] : '0;
            r_o_y      <= place_ok ? p_y[DIM_BITS-1:0] : '0;
            r_o_w      <= place_ok ? p_w : '0;
            r_o_h      <= place_ok ? p_h : '0;
            r_o_turned <= place_ok && p_turn;
        end
    end

    assign o_res_valid  = r_ov;
    assign o_res_status = r_o_status;
    assign o_res_sheet  = r_o_sheet;
    assign o_res_x      = r_o_x;
    assign o_res_y      = r_o_y;
    assign o_res_w      = r_o_w;
    assign o_res_h      = r_o_h;
    assign o_res_turned = r_o_turned;

endmodule

`default_nettype wire

// ===== src/shelf_rectangle_packer_unit.sv =====
// Top level of the next-fit shelf rectangle packer.
// Instantiates srp_front, srp_queue and srp_back; depends on srp_pkg.
//
//   channel   dir  handshake                  payload
//   s_axis    in   tvalid / tready            tdata: size_w, size_h, may_rotate
//                                             tuser: opcode
//   m_axis    out  tvalid / tready            tdata: sheet_number, pos_x, pos_y,
//                                               placed_w, placed_h, turned
//                                             tuser: status
//   cfg       in   i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// One command per clock sustained while m_axis does not stall, one result
// per command. A command passes the front register, the four-entry command
// queue and the back end, which registers its result. The back end settles
// a whole placement (cursor, fresh row, next sheet) combinationally against
// registered copies of the current and the following sheet size.
// Reset is synchronous, active low, and empties the queue, the sheet count
// and the cursor; the sheet table itself needs no clearing pass. A stall on
// m_axis holds the result register and lets the queue fill before s_axis
// tready drops.
`default_nettype none

module shelf_rectangle_packer_unit #(
    parameter int MAX_SHEETS = 64,
    parameter int DIM_BITS   = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // stream in
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // size_w, size_h, may_rotate, zero fill
    input  wire logic [((2*DIM_BITS+1+7)/8)*8-1:0] i_s_axis_tdata,
    // opcode
    input  wire logic [srp_pkg::OPCODE_BITS-1:0]   i_s_axis_tuser,
    // stream out
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // sheet_number, pos_x, pos_y, placed_w, placed_h, turned, zero fill
    output logic [((srp_pkg::SHEET_NUM_BITS+4*DIM_BITS+1+7)/8)*8-1:0] o_m_axis_tdata,
    // status
    output logic [srp_pkg::STATUS_BITS-1:0]        o_m_axis_tuser,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [srp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [DIM_BITS-1:0]               i_cfg_data
);
    import srp_pkg::*;

    localparam int OW = ((SHEET_NUM_BITS + 4*DIM_BITS + 1 + 7) / 8) * 8;
    localparam int QW = $bits(t_ctl) + 2*DIM_BITS;

    // front to queue
    logic                f_valid, f_ready;
    t_ctl                f_ctl;
    logic [DIM_BITS-1:0] f_w, f_h;

    // queue to back
    logic                q_valid, q_ready;
    logic [QW-1:0]       q_data;
    t_ctl                q_ctl;
    logic [DIM_BITS-1:0] q_w, q_h;

    // back results
    t_status                   res_status;
    logic [SHEET_NUM_BITS-1:0] res_sheet;
    logic [DIM_BITS-1:0]       res_x, res_y, res_w, res_h;
    logic                      res_turned;

    srp_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_opcode (i_s_axis_tuser),
        .i_in_w      (i_s_axis_tdata[DIM_BITS-1:0]),
        .i_in_h      (i_s_axis_tdata[2*DIM_BITS-1:DIM_BITS]),
        .i_in_rot    (i_s_axis_tdata[2*DIM_BITS]),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd_ctl   (f_ctl),
        .o_cmd_w     (f_w),
        .o_cmd_h     (f_h)
    );

    srp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  ({f_ctl, f_h, f_w}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    // unpack the queued command
    assign q_w   = q_data[DIM_BITS-1:0];
    assign q_h   = q_data[2*DIM_BITS-1:DIM_BITS];
    assign q_ctl = t_ctl'(q_data[QW-1:2*DIM_BITS]);

    srp_back #(
        .MAX_SHEETS (MAX_SHEETS),
        .DIM_BITS   (DIM_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_valid  (q_valid),
        .o_cmd_ready  (q_ready),
        .i_cmd_ctl    (q_ctl),
        .i_cmd_w      (q_w),
        .i_cmd_h      (q_h),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res_status (res_status),
        .o_res_sheet  (res_sheet),
        .o_res_x      (res_x),
        .o_res_y      (res_y),
        .o_res_w      (res_w),
        .o_res_h      (res_h),
        .o_res_turned (res_turned)
    );

    // pack the result, first field lowest, zero fill on top
    assign o_m_axis_tdata = OW'({res_turned, res_h, res_w, res_y, res_x, res_sheet});
    assign o_m_axis_tuser = res_status;

endmodule

`default_nettype wire

// ===== src/srp_checker.sv =====
// Port-level checks for the shelf rectangle packer, bound to its top level.
// Depends on srp_pkg and on shelf_rectangle_packer_unit.
`default_nettype none

module srp_checker #(
    parameter int DIM_BITS = 24
) (
    input wire logic                                                   i_clk,
    input wire logic                                                   i_rst_n,
    input wire logic                                                   i_m_tvalid,
    input wire logic                                                   i_m_tready,
    input wire logic [((srp_pkg::SHEET_NUM_BITS+4*DIM_BITS+1+7)/8)*8-1:0] i_m_tdata,
    input wire logic [srp_pkg::STATUS_BITS-1:0]                        i_m_tuser
);
    import srp_pkg::*;

    localparam int OW = ((SHEET_NUM_BITS + 4*DIM_BITS + 1 + 7) / 8) * 8;

    // hold a stalled result
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result dropped while stalled");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result word changed while stalled");

    // only placements and loads carry fields
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser != ST_PLACED) && (i_m_tuser != ST_LOADED)
            |-> (i_m_tdata == '0))
        else $error("non-zero fields on a status without payload");

    a_load_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == ST_LOADED) |-> (i_m_tdata[OW-1:SHEET_NUM_BITS] == '0))
        else $error("load result carries placement fields");

endmodule

bind shelf_rectangle_packer_unit srp_checker #(
    .DIM_BITS (DIM_BITS)
) u_srp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// ===== tb/srp_result_checker.sv =====
// Result checker for the shelf rectangle packer: watches the command, result and register
// ports, predicts every result with its own packing state and compares in order.
// Depends on srp_pkg for opcodes, register indexes and status codes.
`timescale 1ns / 1ps

module srp_result_checker #(
    parameter int MAX_SHEETS = 64,
    parameter int DIM_BITS   = 24,
    parameter int CMD_W      = ((2*DIM_BITS+1+7)/8)*8,
    parameter int RES_W      = ((srp_pkg::SHEET_NUM_BITS+4*DIM_BITS+1+7)/8)*8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cmd_valid,
    input  wire logic                             i_cmd_ready,
    // size_w, size_h, may_rotate, zero fill
    input  wire logic [CMD_W-1:0]                 i_cmd_data,
    // opcode
    input  wire logic [srp_pkg::OPCODE_BITS-1:0]  i_cmd_op,
    input  wire logic                             i_res_valid,
    input  wire logic                             i_res_ready,
    // sheet_number, pos_x, pos_y, placed_w, placed_h, turned, zero fill
    input  wire logic [RES_W-1:0]                 i_res_data,
    // status
    input  wire logic [srp_pkg::STATUS_BITS-1:0]  i_res_status,
    input  wire logic                             i_cfg_we,
    input  wire logic [srp_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [DIM_BITS-1:0]              i_cfg_data,
    output int                                    o_mismatches,
    output int                                    o_pending,
    output int                                    o_results
);
    import srp_pkg::*;

    localparam int X_LSB    = SHEET_NUM_BITS;
    localparam int Y_LSB    = X_LSB + DIM_BITS;
    localparam int W_LSB    = Y_LSB + DIM_BITS;
    localparam int H_LSB    = W_LSB + DIM_BITS;
    localparam int TURN_BIT = H_LSB + DIM_BITS;
    localparam int REPORT_MAX = 10;
    localparam int SLOT_BITS  = (MAX_SHEETS > 1) ? $clog2(MAX_SHEETS) : 1;

    typedef logic [DIM_BITS-1:0] t_dim;

    typedef struct packed {
        t_status                   status;
        logic [SHEET_NUM_BITS-1:0] sheet;
        t_dim                      x;
        t_dim                      y;
        t_dim                      w;
        t_dim                      h;
        logic                      turned;
    } t_outcome;

    t_dim        sheet_w_mem [MAX_SHEETS];
    t_dim        sheet_h_mem [MAX_SHEETS];
    int unsigned n_sheets;
    int unsigned cur_sheet;
    longint      cur_x;
    longint      cur_y;
    longint      shelf_h;
    t_dim        trim_l, trim_r, trim_t, trim_b, spacing;
    t_outcome    outcomes_due [$];
    int          bad_count;
    int          seen_count;

    // Try the part as given, then turned, at the cursor; commit the first that fits.
    function automatic bit place_on_shelf(longint w, longint h, bit rot, longint uw, longint uh,
                                          output t_outcome r);
        longint pw, ph;
        int     n_try;
        r = '0;
        n_try = (rot && w != h) ? 2 : 1;
        for (int k = 0; k < n_try; k++) begin
            pw = (k == 1) ? h : w;
            ph = (k == 1) ? w : h;
            if (cur_x + pw <= uw && cur_y + ph <= uh) begin
                r.status = ST_PLACED;
                r.sheet  = cur_sheet[SHEET_NUM_BITS-1:0];
                r.x      = cur_x[DIM_BITS-1:0];
                r.y      = cur_y[DIM_BITS-1:0];
                r.w      = pw[DIM_BITS-1:0];
                r.h      = ph[DIM_BITS-1:0];
                r.turned = (k == 1);
                cur_x += pw + longint'(spacing);
                if (ph > shelf_h) shelf_h = ph;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Current row first, then a fresh row if the current one holds anything.
    function automatic bit fit_on_sheet(longint w, longint h, bit rot, output t_outcome r);
        longint uw, uh;
        uw = longint'(sheet_w_mem[cur_sheet[SLOT_BITS-1:0]]) - longint'(trim_l)
             - longint'(trim_r);
        uh = longint'(sheet_h_mem[cur_sheet[SLOT_BITS-1:0]]) - longint'(trim_t)
             - longint'(trim_b);
        if (place_on_shelf(w, h, rot, uw, uh, r)) return 1'b1;
        if (shelf_h > 0) begin
            cur_x = 0;
            cur_y += shelf_h + longint'(spacing);
            shelf_h = 0;
            if (place_on_shelf(w, h, rot, uw, uh, r)) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_outcome work_out_outcome(logic [OPCODE_BITS-1:0] op, t_dim w, t_dim h,
                                                  logic rot);
        t_outcome r;
        r = '0;
        if (op == OP_CLEAR || op == OP_CLEAR_ALT) begin
            n_sheets  = 0;
            cur_sheet = 0;
            cur_x     = 0;
            cur_y     = 0;
            shelf_h   = 0;
            r.status  = ST_CLEARED;
            return r;
        end
        if (op == OP_LOAD) begin
            if (n_sheets >= MAX_SHEETS) begin
                r.status = ST_TABLE_FULL;
                return r;
            end
            sheet_w_mem[n_sheets[SLOT_BITS-1:0]] = w;
            sheet_h_mem[n_sheets[SLOT_BITS-1:0]] = h;
            r.status = ST_LOADED;
            r.sheet  = n_sheets[SHEET_NUM_BITS-1:0];
            n_sheets++;
            return r;
        end
        if (n_sheets == 0) begin
            r.status = ST_NO_SHEETS;
            return r;
        end
        if (fit_on_sheet(longint'(w), longint'(h), rot, r)) return r;
        // a fresh row opened above stays open when no further sheet exists
        if (cur_sheet + 1 >= n_sheets) begin
            r = '0;
            r.status = ST_EXHAUSTED;
            return r;
        end
        cur_sheet++;
        cur_x   = 0;
        cur_y   = 0;
        shelf_h = 0;
        if (fit_on_sheet(longint'(w), longint'(h), rot, r)) return r;
        r = '0;
        r.status = ST_TOO_BIG;
        return r;
    endfunction

    function automatic string describe(t_outcome r);
        return $sformatf("status=%0d sheet=%0d x=%0d y=%0d w=%0d h=%0d turned=%0d",
                         r.status, r.sheet, r.x, r.y, r.w, r.h, r.turned);
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome seen;
        t_outcome due;
        t_outcome fresh;
        if (!i_rst_n) begin
            foreach (sheet_w_mem[i]) begin
                sheet_w_mem[i] = '0;
                sheet_h_mem[i] = '0;
            end
            n_sheets   = 0;
            cur_sheet  = 0;
            cur_x      = 0;
            cur_y      = 0;
            shelf_h    = 0;
            trim_l     = '0;
            trim_r     = '0;
            trim_t     = '0;
            trim_b     = '0;
            spacing    = '0;
            bad_count  = 0;
            seen_count = 0;
            outcomes_due.delete();
            o_mismatches <= 0;
            o_pending    <= 0;
            o_results    <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TRIM_LEFT:   trim_l  = i_cfg_data;
                    CFG_TRIM_RIGHT:  trim_r  = i_cfg_data;
                    CFG_TRIM_TOP:    trim_t  = i_cfg_data;
                    CFG_TRIM_BOTTOM: trim_b  = i_cfg_data;
                    CFG_GAP:         spacing = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd_valid && i_cmd_ready) begin
                fresh = work_out_outcome(i_cmd_op, i_cmd_data[DIM_BITS-1:0],
                                         i_cmd_data[2*DIM_BITS-1:DIM_BITS],
                                         i_cmd_data[2*DIM_BITS]);
                outcomes_due.insert(outcomes_due.size(), fresh);
            end
            if (i_res_valid && i_res_ready) begin
                seen.status = t_status'(i_res_status);
                seen.sheet  = i_res_data[SHEET_NUM_BITS-1:0];
                seen.x      = i_res_data[X_LSB +: DIM_BITS];
                seen.y      = i_res_data[Y_LSB +: DIM_BITS];
                seen.w      = i_res_data[W_LSB +: DIM_BITS];
                seen.h      = i_res_data[H_LSB +: DIM_BITS];
                seen.turned = i_res_data[TURN_BIT];
                if (outcomes_due.size() == 0) begin
                    if (bad_count < REPORT_MAX)
                        $display("[%0t] unexpected result: %s", $realtime, describe(seen));
                    bad_count++;
                end else begin
                    due = outcomes_due.pop_front();
                    if (seen !== due) begin
                        if (bad_count < REPORT_MAX) begin
                            $display("[%0t] result %0d differs", $realtime, seen_count);
                            $display("    expected %s", describe(due));
                            $display("    actual   %s", describe(seen));
                        end
                        bad_count++;
                    end
                end
                seen_count++;
            end
            o_mismatches <= bad_count;
            o_pending    <= outcomes_due.size();
            o_results    <= seen_count;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the shelf rectangle packer testbench: clock, reset, register programming and
// command stimulus with random gaps and stalls; checking is left to srp_result_checker.
// Depends on srp_pkg, shelf_rectangle_packer_unit and srp_result_checker.
`timescale 1ns / 1ps

module tb;
    import srp_pkg::*;

    localparam int     MAX_SHEETS = 64;
    localparam int     DIM_BITS   = 24;
    localparam int     CMD_W      = ((2*DIM_BITS+1+7)/8)*8;
    localparam int     RES_W      = ((SHEET_NUM_BITS+4*DIM_BITS+1+7)/8)*8;
    localparam int     IDLE_MAX   = 19;    // longest gap or stall drawn per word
    localparam int     SETTLE     = 8;     // extra wait after the last result, before a register write
    localparam int     QUIET_MAX  = 2000;  // cycles with no word moving before giving up
    localparam longint DIM_TOP    = (longint'(1) << DIM_BITS) - 1;
    localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cmd_valid = 1'b0;
    logic                      cmd_ready;
    logic [CMD_W-1:0]          cmd_data  = '0;
    logic [OPCODE_BITS-1:0]    cmd_op    = OP_PLACE;
    logic                      res_valid;
    logic                      res_ready = 1'b0;
    logic [RES_W-1:0]          res_data;
    logic [STATUS_BITS-1:0]    res_status;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_idx   = CFG_TRIM_LEFT;
    logic [DIM_BITS-1:0]       cfg_data  = '0;

    int     mismatches;
    int     pending;
    int     results;
    int     commands_sent = 0;
    int     settings_used = 0;
    int     job_count     = 0;
    int     quiet_cycles  = 0;
    bit     gaps_off      = 1'b0;
    bit     stalls_off    = 1'b0;
    longint margin_w      = 0;   // trim_left + trim_right of the current setting
    longint margin_h      = 0;   // trim_top + trim_bottom of the current setting

    initial begin
        forever #2 clk = ~clk;
    end

    shelf_rectangle_packer_unit #(
        .MAX_SHEETS (MAX_SHEETS),
        .DIM_BITS   (DIM_BITS)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (cmd_valid),
        .o_s_axis_tready (cmd_ready),
        .i_s_axis_tdata  (cmd_data),    // size_w, size_h, may_rotate
        .i_s_axis_tuser  (cmd_op),      // opcode
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),    // sheet_number, pos_x, pos_y, placed_w, placed_h, turned
        .o_m_axis_tuser  (res_status),  // status
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    srp_result_checker #(
        .MAX_SHEETS (MAX_SHEETS),
        .DIM_BITS   (DIM_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .i_cmd_data   (cmd_data),
        .i_cmd_op     (cmd_op),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .i_res_status (res_status),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    // Watchdog: a stuck handshake or a lost result stops every word from moving.
    always @(posedge clk) begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_MAX) begin
            $display("no word moved for %0d cycles, %0d results still due", QUIET_MAX, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: draw a stall per word; now and then toggle a stretch with no stalls.
    initial begin : result_sink
        int hold;
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0) stalls_off = !stalls_off;
            hold = stalls_off ? 0 : $urandom_range(0, IDLE_MAX);
            if (hold > 0) begin
                res_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!(res_valid && res_ready));
        end
    end

    function automatic logic [DIM_BITS-1:0] rand_dim();
        return DIM_BITS'($urandom_range(0, DIM_TOP));
    endfunction

    // Sheet side = margins plus a usable length drawn from the upper half of the span.
    function automatic logic [DIM_BITS-1:0] sheet_side(longint margin, longint span);
        longint side;
        side = margin + longint'($urandom_range(span / 2, span));
        return (side > DIM_TOP) ? DIM_MAX : side[DIM_BITS-1:0];
    endfunction

    // Present one command word after a drawn gap and hold it until accepted.
    task automatic send_command(logic [OPCODE_BITS-1:0] op, logic [DIM_BITS-1:0] w,
                                logic [DIM_BITS-1:0] h, logic rot);
        int pause;
        pause = gaps_off ? 0 : $urandom_range(0, IDLE_MAX);
        if (pause > 0) begin
            cmd_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_op    <= op;
        cmd_data  <= {rot, h, w};
        do @(posedge clk); while (!(cmd_valid && cmd_ready));
        commands_sent++;
    endtask

    // Drop valid and wait until every predicted result has been taken, then let the
    // pipeline settle so a register write never overtakes a command in flight.
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all five registers on consecutive edges; write enable stays high throughout.
    task automatic program_regs(logic [DIM_BITS-1:0] tl, logic [DIM_BITS-1:0] tr,
                                logic [DIM_BITS-1:0] tt, logic [DIM_BITS-1:0] tbm,
                                logic [DIM_BITS-1:0] gp);
        logic [DIM_BITS-1:0]     vals [5];
        logic [CFG_IDX_BITS-1:0] idxs [5];
        vals = '{tl, tr, tt, tbm, gp};
        idxs = '{CFG_TRIM_LEFT, CFG_TRIM_RIGHT, CFG_TRIM_TOP, CFG_TRIM_BOTTOM, CFG_GAP};
        for (int i = 0; i < 5; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idxs[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        margin_w = longint'(tl) + longint'(tr);
        margin_h = longint'(tt) + longint'(tbm);
        settings_used++;
    endtask

    // One job: clear, load a few sheets, place a run of parts sized to them. Some jobs skip
    // the clear, some fill the table past its end, and some words are noise.
    task automatic run_job();
        int     mode, n_load, n_parts, div, roll;
        longint span_w, span_h, mw, mh;
        logic [DIM_BITS-1:0] w, h;
        mode = $urandom_range(0, 9);
        gaps_off = ($urandom_range(0, 3) == 0);
        mw = margin_w;
        mh = margin_h;
        if (mode <= 6) begin
            span_w = longint'($urandom_range(16, 3000));
            span_h = longint'($urandom_range(16, 3000));
            div    = $urandom_range(1, 6);
        end else if (mode <= 8) begin
            span_w = longint'($urandom_range(DIM_TOP / 4, DIM_TOP));
            span_h = longint'($urandom_range(DIM_TOP / 4, DIM_TOP));
            div    = $urandom_range(1, 4);
        end else begin
            // wild: sizes over the whole field, margins ignored
            span_w = DIM_TOP;
            span_h = DIM_TOP;
            mw     = 0;
            mh     = 0;
            div    = 1;
        end
        n_load  = (job_count % 16 == 5) ? $urandom_range(MAX_SHEETS, MAX_SHEETS + 2)
                                        : $urandom_range(1, 6);
        n_parts = $urandom_range(4, 40);
        job_count++;

        if ($urandom_range(0, 7) != 0)
            send_command($urandom_range(0, 1) ? OP_CLEAR : OP_CLEAR_ALT,
                         rand_dim(), rand_dim(), 1'($urandom_range(0, 1)));
        for (int s = 0; s < n_load; s++)
            send_command(OP_LOAD, sheet_side(mw, span_w), sheet_side(mh, span_h),
                         1'($urandom_range(0, 1)));
        for (int p = 0; p < n_parts; p++) begin
            roll = $urandom_range(0, 99);
            if (roll < 7) begin
                send_command(OPCODE_BITS'($urandom_range(OP_PLACE, OP_CLEAR_ALT)),
                             rand_dim(), rand_dim(), 1'($urandom_range(0, 1)));
            end else if (roll < 13) begin
                // another sheet mid-run lets an exhausted run move on
                send_command(OP_LOAD, sheet_side(mw, span_w), sheet_side(mh, span_h),
                             1'($urandom_range(0, 1)));
            end else begin
                w = DIM_BITS'($urandom_range(0, span_w / div));
                h = DIM_BITS'($urandom_range(0, span_h / div));
                if (roll < 16) w = '0;
                else if (roll < 19) h = '0;
                send_command(OP_PLACE, w, h, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic fill_phase(int count);
        int goal;
        goal = commands_sent + count;
        while (commands_sent < goal) run_job();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Setting with no margins and no gap; directed walk through the special cases.
        program_regs('0, '0, '0, '0, '0);
        send_command(OP_PLACE, DIM_MAX, DIM_MAX, 1'b1);    // nothing loaded yet
        send_command(OP_LOAD, 24'd1000, 24'd500, 1'b0);
        send_command(OP_PLACE, '0, '0, 1'b0);              // zero-sized part at the origin
        send_command(OP_PLACE, 24'd400, 24'd100, 1'b0);
        send_command(OP_PLACE, 24'd100, 24'd700, 1'b1);    // only fits turned on a new row
        send_command(OP_PLACE, 24'd600, 24'd600, 1'b1);    // square, no sheet left
        send_command(OP_LOAD, DIM_MAX, DIM_MAX, 1'b1);
        send_command(OP_PLACE, 24'd600, 24'd600, 1'b0);    // moves on to the new sheet
        send_command(OP_PLACE, DIM_MAX, DIM_MAX, 1'b1);    // no further sheet
        send_command(OP_LOAD, 24'd10, 24'd10, 1'b0);
        send_command(OP_PLACE, DIM_MAX, DIM_MAX, 1'b0);    // too big for the fresh sheet
        send_command(OP_PLACE, 24'd5, 24'd10, 1'b1);
        send_command(OP_PLACE, 24'd10, 24'd5, 1'b1);       // fits only turned
        send_command(OP_CLEAR_ALT, DIM_MAX, '0, 1'b1);
        send_command(OP_PLACE, 24'd1, 24'd1, 1'b0);        // table empty again
        send_command(OP_LOAD, '0, '0, 1'b0);
        send_command(OP_PLACE, '0, '0, 1'b1);              // zero part on a zero sheet
        send_command(OP_PLACE, 24'd1, '0, 1'b1);           // empty row, nowhere to go
        send_command(OP_LOAD, DIM_MAX, 24'd1, 1'b0);
        send_command(OP_PLACE, DIM_MAX, 24'd1, 1'b0);
        send_command(OP_CLEAR, DIM_MAX, DIM_MAX, 1'b1);
        fill_phase(380);
        drain();

        // Modest margins and gap: the bulk of ordinary packing.
        program_regs(DIM_BITS'($urandom_range(0, 200)), DIM_BITS'($urandom_range(0, 200)),
                     DIM_BITS'($urandom_range(0, 200)), DIM_BITS'($urandom_range(0, 200)),
                     DIM_BITS'($urandom_range(0, 50)));
        fill_phase(350);
        drain();

        // Every register at its top: the usable area goes negative and nothing fits.
        program_regs(DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX);
        fill_phase(100);
        drain();

        // Huge gap only: every part after the first is pushed to a new row or sheet.
        program_regs('0, '0, '0, '0, DIM_MAX);
        fill_phase(150);
        drain();

        // Registers anywhere in their range.
        program_regs(rand_dim(), rand_dim(), rand_dim(), rand_dim(), rand_dim());
        fill_phase(100);
        drain();

        program_regs(DIM_BITS'($urandom_range(0, 1000)), DIM_BITS'($urandom_range(0, 1000)),
                     DIM_BITS'($urandom_range(0, 1000)), DIM_BITS'($urandom_range(0, 1000)),
                     DIM_BITS'($urandom_range(0, 100)));
        fill_phase(400);
        drain();

        $display("covered %0d commands in %0d jobs under %0d register settings",
                 commands_sent, job_count, settings_used);
        $display("%0d results compared, %0d differed", results, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
